/* rtl/core/bbe_pkg.sv */
// shared constants for the edge-normalised box blur
package bbe_pkg;

  // pixel and frame geometry
  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int CFG_W_W      = 12;
  localparam int CFG_H_W      = 13;
  localparam int HEIGHT_LIMIT = 4096;

  // apb register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // request kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

endpackage

/* rtl/core/bbe_in_if.sv */
// input request channel: pixel or drain tick
interface bbe_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [bbe_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

/* rtl/core/bbe_out_if.sv */
// output request channel: blurred pixel with end-of-frame mark
interface bbe_out_if;
  logic                       valid;
  logic                       ready;
  logic [bbe_pkg::PIX_W-1:0]  pixel_out;
  logic                       frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* rtl/core/box_blur_edge_normalized.sv */
// Edge-normalised box blur: line memory, window scan sequencer and divider.
// A request that yields no output is taken while idle; one that yields an output
// runs a window scan, one line-memory read per window pixel, then a bit-serial
// divider, and no new request is taken until the result is registered.
// Reset is synchronous; the line memory is not cleared, no clearing pass.
module box_blur_edge_normalized #(
  parameter int MAX_WIDTH = 2048,
  parameter int RADIUS    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  bbe_in_if.sink                            pixels,
  bbe_out_if.source                         results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bbe_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bbe_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bbe_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int STORE_ROWS = 2 * RADIUS + 2;
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W      = (WID_W > bbe_pkg::CFG_W_W) ? WID_W : bbe_pkg::CFG_W_W;
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(MAX_WIDTH * bbe_pkg::HEIGHT_LIMIT + 1) + 1;
  localparam int WIN        = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int SUM_W      = $clog2(WIN * 255 + 1);
  localparam int WC_W       = $clog2(WIN + 1);
  localparam int DIV_W      = $clog2(SUM_W + 1);
  localparam int ROW_W      = bbe_pkg::ROW_W;
  localparam int PIX_W      = bbe_pkg::PIX_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_DIV, S_DONE} state_t;

  state_t                 state;
  logic [bbe_pkg::CFG_W_W-1:0] image_width;
  logic [bbe_pkg::CFG_H_W-1:0] image_height;
  logic [ROW_W-1:0]       in_row, out_row;
  logic [COL_W-1:0]       in_col, out_col;
  logic [SLOT_W-1:0]      in_slot, out_slot;
  logic [CNT_W-1:0]       in_count, out_count;
  logic                   complete;
  logic [ROW_W-1:0]       scan_row, scan_row_end;
  logic [SLOT_W-1:0]      scan_slot;
  logic [COL_W-1:0]       scan_col, scan_col_beg, scan_col_end;
  logic                   acc_en;
  logic [SUM_W-1:0]       sum;
  logic [WC_W-1:0]        cnt;
  logic [WC_W-1:0]        rem;
  logic [DIV_W-1:0]       div_left;
  logic                   ovalid;
  logic [PIX_W-1:0]       opix;
  logic                   olast;

  logic [PIX_W-1:0]       mem [DEPTH];
  logic [PIX_W-1:0]       rd_data;
  logic [ADDR_W-1:0]      rd_addr, wr_addr;
  logic                   wr_en;

  logic [WID_W-1:0]       w_eff;
  logic [bbe_pkg::CFG_H_W-1:0] h_eff;
  logic [CMP_W-1:0]       w_raw;
  logic [CNT_W:0]         lag;
  logic                   accept, cfg_wr, emit;
  logic [COL_W:0]         in_col_inc, out_col_inc, c_hi;
  logic [ROW_W:0]         in_row_inc, out_row_inc, r_hi;
  logic [ROW_W-1:0]       k_up, r0, r1;
  logic [COL_W-1:0]       c0, c1;
  logic [SLOT_W:0]        slot_add;
  logic [SLOT_W-1:0]      slot0;
  logic [WC_W:0]          trial;
  logic                   out_wrap, out_last;

  // effective geometry
  assign w_raw = CMP_W'(image_width);
  always_comb begin
    if (image_width == '0) begin
      w_eff = WID_W'(1);
    end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(w_raw);
    end
    if (image_height == '0) begin
      h_eff = bbe_pkg::CFG_H_W'(1);
    end else if (image_height > bbe_pkg::CFG_H_W'(bbe_pkg::HEIGHT_LIMIT)) begin
      h_eff = bbe_pkg::CFG_H_W'(bbe_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = image_height;
    end
  end

  assign lag = (CNT_W+1)'(w_eff) * (CNT_W+1)'(RADIUS) + (CNT_W+1)'(RADIUS);

  // handshakes
  assign pixels.ready = (state == S_IDLE);
  assign accept       = pixels.valid && pixels.ready;
  assign cfg_wr       = psel && penable && pwrite;
  assign pready       = 1'b1;
  assign prdata = (paddr[2] == bbe_pkg::REG_HEIGHT) ? bbe_pkg::APB_DATA_W'(image_height)
                                                    : bbe_pkg::APB_DATA_W'(image_width);

  // input position advance
  assign in_col_inc = (COL_W+1)'(in_col) + 1'b1;
  assign in_row_inc = (ROW_W+1)'(in_row) + 1'b1;

  // decide whether this request releases an output
  always_comb begin
    if (pixels.action == bbe_pkg::ACT_DRAIN) begin
      emit = complete;
    end else begin
      emit = !complete &&
             ((CNT_W+1)'(in_count) + 1'b1 > (CNT_W+1)'(out_count) + lag);
    end
  end

  // window bounds around the next output pixel
  always_comb begin
    k_up = (out_row >= ROW_W'(RADIUS)) ? ROW_W'(RADIUS) : out_row;
    r0   = out_row - k_up;
    r_hi = (ROW_W+1)'(out_row) + (ROW_W+1)'(RADIUS);
    r1   = (r_hi > (ROW_W+1)'(h_eff - 1'b1)) ? ROW_W'(h_eff - 1'b1) : ROW_W'(r_hi);
    c0   = (out_col >= COL_W'(RADIUS)) ? out_col - COL_W'(RADIUS) : '0;
    c_hi = (COL_W+1)'(out_col) + (COL_W+1)'(RADIUS);
    c1   = (c_hi > (COL_W+1)'(w_eff - 1'b1)) ? COL_W'(w_eff - 1'b1) : COL_W'(c_hi);
    if (out_slot >= SLOT_W'(k_up)) begin
      slot_add = (SLOT_W+1)'(out_slot) - (SLOT_W+1)'(k_up);
    end else begin
      slot_add = (SLOT_W+1)'(out_slot) + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(k_up);
    end
    slot0 = SLOT_W'(slot_add);
  end

  // output position advance
  assign out_col_inc = (COL_W+1)'(out_col) + 1'b1;
  assign out_row_inc = (ROW_W+1)'(out_row) + 1'b1;
  assign out_wrap    = out_col_inc >= (COL_W+1)'(w_eff);
  assign out_last    = out_wrap && (out_row_inc >= (ROW_W+1)'(h_eff));

  // divider trial subtract
  assign trial = {rem, sum[SUM_W-1]};

  // line memory
  assign wr_en   = accept && (pixels.action == bbe_pkg::ACT_PIXEL) && !complete;
  assign wr_addr = ADDR_W'(in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign rd_addr = ADDR_W'(scan_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(scan_col);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= pixels.pixel_in;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer, positions and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= bbe_pkg::CFG_W_W'(256);
      image_height <= bbe_pkg::CFG_H_W'(256);
      in_row       <= '0;
      in_col       <= '0;
      in_slot      <= '0;
      in_count     <= '0;
      out_row      <= '0;
      out_col      <= '0;
      out_slot     <= '0;
      out_count    <= '0;
      complete     <= 1'b0;
      acc_en       <= 1'b0;
      ovalid       <= 1'b0;
    end else begin
      // one memory read per scan cycle, summed in the cycle after
      acc_en <= (state == S_SCAN);
      if (results.valid && results.ready && state != S_DONE) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // store the pixel and advance the input position
            if (wr_en) begin
              in_count <= in_count + 1'b1;
              if (in_col_inc >= (COL_W+1)'(w_eff)) begin
                in_col  <= '0;
                in_row  <= ROW_W'(in_row_inc);
                in_slot <= (in_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : in_slot + 1'b1;
                if (in_row_inc >= (ROW_W+1)'(h_eff)) begin
                  complete <= 1'b1;
                end
              end else begin
                in_col <= COL_W'(in_col_inc);
              end
            end
            if (emit) begin
              scan_row     <= r0;
              scan_row_end <= r1;
              scan_slot    <= slot0;
              scan_col     <= c0;
              scan_col_beg <= c0;
              scan_col_end <= c1;
              sum          <= '0;
              cnt          <= '0;
              state        <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // one memory read per window pixel
          cnt <= cnt + 1'b1;
          if (scan_col == scan_col_end) begin
            scan_col <= scan_col_beg;
            if (scan_row == scan_row_end) begin
              state <= S_WAIT;
            end else begin
              scan_row  <= scan_row + 1'b1;
              scan_slot <= (scan_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : scan_slot + 1'b1;
            end
          end else begin
            scan_col <= scan_col + 1'b1;
          end
        end
        S_WAIT: begin
          rem      <= '0;
          div_left <= DIV_W'(SUM_W);
          state    <= S_DIV;
        end
        S_DIV: begin
          // restoring division, quotient shifts into the sum register
          if (trial >= (WC_W+1)'(cnt)) begin
            rem <= WC_W'(trial - (WC_W+1)'(cnt));
            sum <= {sum[SUM_W-2:0], 1'b1};
          end else begin
            rem <= WC_W'(trial);
            sum <= {sum[SUM_W-2:0], 1'b0};
          end
          div_left <= div_left - 1'b1;
          if (div_left == DIV_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ovalid || results.ready) begin
            ovalid <= 1'b1;
            opix   <= sum[PIX_W-1:0];
            olast  <= out_last;
            state  <= S_IDLE;
            if (out_last) begin
              // frame finished, start the next one
              in_row    <= '0;
              in_col    <= '0;
              in_slot   <= '0;
              in_count  <= '0;
              out_row   <= '0;
              out_col   <= '0;
              out_slot  <= '0;
              out_count <= '0;
              complete  <= 1'b0;
            end else begin
              out_count <= out_count + 1'b1;
              if (out_wrap) begin
                out_col  <= '0;
                out_row  <= ROW_W'(out_row_inc);
                out_slot <= (out_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : out_slot + 1'b1;
              end else begin
                out_col <= COL_W'(out_col_inc);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // accumulate read data in the cycle after its address
      if (acc_en) begin
        sum <= sum + SUM_W'(rd_data);
      end
      // register write restarts the frame
      if (cfg_wr) begin
        if (paddr[2] == bbe_pkg::REG_HEIGHT) begin
          image_height <= pwdata[bbe_pkg::CFG_H_W-1:0];
        end else begin
          image_width <= pwdata[bbe_pkg::CFG_W_W-1:0];
        end
        in_row    <= '0;
        in_col    <= '0;
        in_slot   <= '0;
        in_count  <= '0;
        out_row   <= '0;
        out_col   <= '0;
        out_slot  <= '0;
        out_count <= '0;
        complete  <= 1'b0;
      end
    end
  end

  assign results.valid      = ovalid;
  assign results.pixel_out  = opix;
  assign results.frame_last = olast;

`ifndef SYNTHESIS
  // the window always holds its centre pixel
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt != '0))
    else $error("divider started with empty window");

  // row slots stay inside the line memory
  a_slots: assert property (@(posedge clk) disable iff (rst)
    (in_slot < SLOT_W'(STORE_ROWS)) && (out_slot < SLOT_W'(STORE_ROWS)))
    else $error("row slot out of range");

  // outputs never overtake inputs
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_count <= in_count)
    else $error("output count passed input count");

  // a finished frame leaves the positions cleared
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!ovalid || results.ready) && out_last && !cfg_wr)
    |=> (out_count == '0 && in_count == '0 && !complete))
    else $error("frame did not restart after last output");
`endif

endmodule

/* bench/tb_top.sv */
// testbench for the edge-normalised box blur: predicts each output pixel and checks it
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 2048;
  localparam int RAD = 5;
  localparam int STORE_ROWS = 2 * RAD + 2;
  localparam int SETTLE = 200;
  localparam int PIX_W = bbe_pkg::PIX_W;
  localparam int CFG_W_W = bbe_pkg::CFG_W_W;
  localparam int CFG_H_W = bbe_pkg::CFG_H_W;
  localparam int HEIGHT_LIMIT = bbe_pkg::HEIGHT_LIMIT;
  localparam int APB_ADDR_W = bbe_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = bbe_pkg::APB_DATA_W;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } blur_pix_t;

  // blur predictor and queue of expected output pixels
  class blur_board;
    logic [PIX_W-1:0] rows_mem [STORE_ROWS][MAXW];
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    int unsigned in_r, in_c, out_r, out_c;
    bit frame_in_done;
    blur_pix_t awaited[$];
    int errors;

    function new();
      foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
      width_reg = 256;
      height_reg = 256;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      frame_in_done = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAXW) return MAXW;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == bbe_pkg::REG_WIDTH) width_reg = val[CFG_W_W-1:0];
      else height_reg = val[CFG_H_W-1:0];
      restart();
    endfunction

    // truncated mean of the in-frame part of the window
    function logic [PIX_W-1:0] window_mean(int unsigned r, int unsigned c);
      int unsigned r0, r1, c0, c1, total, cnt;
      r0 = (r >= RAD) ? r - RAD : 0;
      c0 = (c >= RAD) ? c - RAD : 0;
      r1 = r + RAD;
      c1 = c + RAD;
      total = 0;
      cnt = 0;
      if (r1 > eff_h() - 1) r1 = eff_h() - 1;
      if (c1 > eff_w() - 1) c1 = eff_w() - 1;
      for (int unsigned i = r0; i <= r1; i++)
        for (int unsigned j = c0; j <= c1; j++) begin
          total += rows_mem[i % STORE_ROWS][j % MAXW];
          cnt++;
        end
      return (cnt == 0) ? '0 : PIX_W'(total / cnt);
    endfunction

    // note an accepted request; returns 1 if it had any effect
    function bit note_request(logic act, logic [PIX_W-1:0] px);
      int unsigned w, h, got, sent;
      bit emit;
      blur_pix_t e;
      w = eff_w();
      h = eff_h();
      if (act == bbe_pkg::ACT_PIXEL) begin
        if (frame_in_done) return 0;
        rows_mem[in_r % STORE_ROWS][in_c % MAXW] = px;
        in_c++;
        if (in_c >= w) begin
          in_c = 0;
          in_r++;
          if (in_r >= h) frame_in_done = 1;
        end
        got = frame_in_done ? h * w : in_r * w + in_c;
        sent = out_r * w + out_c;
        emit = got > sent + RAD * w + RAD;
        if (!emit) return 1;
      end else if (!frame_in_done) begin
        return 0;
      end
      e.pix = window_mean(out_r, out_c);
      e.last = 0;
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
        if (out_r >= h) e.last = 1;
      end
      awaited.push_back(e);
      if (e.last) restart();
      return 1;
    endfunction

    function void check_result(logic [PIX_W-1:0] px, logic last);
      blur_pix_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected output pixel_out=%0d frame_last=%0d", $time, px, last);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (px !== e.pix) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, e.pix, px);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: frame_last expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  bbe_in_if  pix_if();
  bbe_out_if res_if();
  blur_board board;
  bit calm;
  int useful;

  box_blur_edge_normalized DUT (
    .clk(clk), .rst(rst), .pixels(pix_if), .results(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // wait until the block has nothing left to deliver
  task automatic wait_idle();
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, setup then access
  task automatic write_reg(logic idx, logic [31:0] val);
    wait_idle();
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= APB_ADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      pix_if.valid <= 0;
      repeat ($urandom_range(1, 11) - 1) @(negedge clk);
    end
  endtask

  // present one request and hold it until accepted
  task automatic send(logic act, logic [PIX_W-1:0] px);
    sender_gap();
    @(negedge clk);
    pix_if.valid <= 1;
    pix_if.action <= act;
    pix_if.pixel_in <= px;
    do @(posedge clk); while (!pix_if.ready);
    if (board.note_request(act, px)) useful++;
  endtask

  task automatic park();
    @(negedge clk);
    pix_if.valid <= 0;
  endtask

  // one full frame, with some ignored requests mixed in when noisy
  task automatic run_frame(int unsigned w, int unsigned h, bit noisy);
    write_reg(bbe_pkg::REG_WIDTH, w);
    write_reg(bbe_pkg::REG_HEIGHT, h);
    while (!board.frame_in_done) begin
      if (noisy && $urandom_range(0, 19) == 0) send(bbe_pkg::ACT_DRAIN, PIX_W'($urandom));
      else send(bbe_pkg::ACT_PIXEL, PIX_W'($urandom));
    end
    while (board.frame_in_done) begin
      if (noisy && $urandom_range(0, 9) == 0) send(bbe_pkg::ACT_PIXEL, PIX_W'($urandom));
      else send(bbe_pkg::ACT_DRAIN, PIX_W'($urandom));
    end
    park();
  endtask

  // result side: random stalls, check at the accepting edge
  initial begin
    res_if.ready = 0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      res_if.ready <= 1;
      @(posedge clk);
      if (res_if.valid && res_if.ready)
        board.check_result(res_if.pixel_out, res_if.frame_last);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    board = new();
    calm = 0;
    useful = 0;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    pix_if.valid = 0; pix_if.action = bbe_pkg::ACT_PIXEL; pix_if.pixel_in = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: drain before frame end, extremes of pixel value, ignored pixel
    write_reg(bbe_pkg::REG_WIDTH, 3);
    write_reg(bbe_pkg::REG_HEIGHT, 2);
    send(bbe_pkg::ACT_DRAIN, 8'hFF);
    send(bbe_pkg::ACT_PIXEL, 8'h00);
    send(bbe_pkg::ACT_PIXEL, 8'hFF);
    send(bbe_pkg::ACT_PIXEL, 8'hFF);
    send(bbe_pkg::ACT_PIXEL, 8'h00);
    send(bbe_pkg::ACT_PIXEL, 8'hFF);
    send(bbe_pkg::ACT_PIXEL, 8'h80);
    send(bbe_pkg::ACT_PIXEL, 8'h7F);
    while (board.frame_in_done) send(bbe_pkg::ACT_DRAIN, 8'h00);
    park();
    // register write in mid-frame restarts it
    write_reg(bbe_pkg::REG_WIDTH, 4);
    send(bbe_pkg::ACT_PIXEL, 8'hFF);
    send(bbe_pkg::ACT_PIXEL, 8'hFF);
    park();
    write_reg(bbe_pkg::REG_HEIGHT, 3);
    // single-pixel frame
    run_frame(1, 1, 0);
    // zero width and zero height
    run_frame(0, 3, 0);
    run_frame(5, 0, 0);
    // oversized register values, partial frame then restart
    write_reg(bbe_pkg::REG_WIDTH, 4095);
    write_reg(bbe_pkg::REG_HEIGHT, 8191);
    repeat (20) send(bbe_pkg::ACT_PIXEL, PIX_W'($urandom));
    park();

    // random frames, mostly small
    useful = 0;
    while (useful < 1850) begin
      if (useful > 1650) calm = 1;
      if ($urandom_range(0, 15) == 0)
        run_frame($urandom_range(12, 40), $urandom_range(1, 14), 1);
      else
        run_frame($urandom_range(1, 12), $urandom_range(1, 9), $urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        // pixels for a frame that may be left unfinished, followed by a restart
        write_reg(bbe_pkg::REG_WIDTH, $urandom_range(1, 8));
        write_reg(bbe_pkg::REG_HEIGHT, $urandom_range(2, 8));
        repeat ($urandom_range(1, 30)) send(bbe_pkg::ACT_PIXEL, PIX_W'($urandom));
        park();
      end
    end

    wait_idle();
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/bbe_pkg.sv
rtl/core/bbe_in_if.sv
rtl/core/bbe_out_if.sv
rtl/core/box_blur_edge_normalized.sv
bench/tb_top.sv
